// ===== src/aspb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package aspb_pkg;

  localparam int RING_BYTES_DEF = 128;
  localparam int QUEUE_DEPTH    = 2;

  localparam int ADDR_W  = 24;
  localparam int FETCH_W = 25;
  localparam int LEN_W   = 24;
  localparam int RATE_W  = 16;
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 8;
  localparam int TICK_W  = 8;

  localparam int PUMP_THRESHOLD = 32;
  localparam logic [BYTE_W-1:0] IDLE_SAMPLE = 8'h7F;
  localparam logic [TICK_W-1:0] DIVISOR_RESET = 8'd42;
  localparam logic [TICK_W-1:0] DIVISOR_ZERO_RATE = 8'hFF;

  localparam int TICK_HZ   = 8000000 / 8;
  localparam int DIV_W     = $clog2(TICK_HZ);
  localparam int DIV_NUMER = TICK_HZ - 1;

  typedef enum logic [1:0] {
    ACT_PLAY = 2'd0,
    ACT_BYTE = 2'd1,
    ACT_TICK = 2'd2,
    ACT_PUMP = 2'd3
  } action_e;

  typedef struct packed {
    action_e             action;
    logic                rate_zero;
    logic [ADDR_W-1:0]   start_address;
    logic [LEN_W-1:0]    length;
    logic [RATE_W-1:0]   sample_rate_hz;
    logic [BYTE_W-1:0]   flash_byte;
  } cmd_t;

  typedef struct packed {
    logic               done;
    logic [TICK_W-1:0]  divisor;
  } div_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_RESP = 2'd2
  } back_state_e;

endpackage
`default_nettype wire

// ===== src/audio_sample_playback_buffer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Playback buffer for 8-bit PCM audio fed from flash memory.
// The input channel carries one word per event: a play command with start address,
// length and sample rate, a byte returned by flash, a 1 MHz timer tick, or a pump check.
// The output channel returns exactly one word per input word, in order: a sample when
// a sample period ends, a flash read request when one is issued, and the playing flag.
// A two-entry command queue sits between the input decoder and the execution engine,
// and the result sits in an output register, so the input keeps accepting words while
// a result waits to be taken.
// Byte, tick and pump words and play words with a zero rate pass from the queue through
// the response state into the output register. A play word with a nonzero rate first
// waits on a bit-serial divider that produces one quotient bit per cycle. The engine
// handles one word at a time and takes no new word from the queue until the current
// one has been loaded into the output register.
// When the receiver stalls, the result is held and the engine stops after its current
// word; the queue then fills and input ready drops.
// Reset empties the ring and the queue, clears the addresses and the outstanding count,
// and sets the sample divisor to 42. The ring contents are not cleared.
module audio_sample_playback_buffer #(
  parameter int RING_BYTES = aspb_pkg::RING_BYTES_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [1:0]                        action_i,
  input  wire logic [aspb_pkg::ADDR_W-1:0]       start_address_i,
  input  wire logic [aspb_pkg::LEN_W-1:0]        length_i,
  input  wire logic [aspb_pkg::RATE_W-1:0]       sample_rate_hz_i,
  input  wire logic [aspb_pkg::BYTE_W-1:0]       flash_byte_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic                                   sample_valid_o,
  output logic [aspb_pkg::BYTE_W-1:0]            sample_o,
  output logic                                   read_request_valid_o,
  output logic [aspb_pkg::ADDR_W-1:0]            read_address_o,
  output logic [aspb_pkg::COUNT_W-1:0]           read_count_o,
  output logic                                   playing_o
);

  logic               cmd_valid;
  aspb_pkg::cmd_t     cmd;
  logic               cmd_pop;
  logic               div_start;
  aspb_pkg::div_rsp_t div_rsp;

  aspb_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .start_address_i  (start_address_i),
    .length_i         (length_i),
    .sample_rate_hz_i (sample_rate_hz_i),
    .flash_byte_i     (flash_byte_i),
    .cmd_valid_o      (cmd_valid),
    .cmd_o            (cmd),
    .cmd_pop_i        (cmd_pop)
  );

  aspb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .rate_i  (cmd.sample_rate_hz),
    .rsp_o   (div_rsp)
  );

  aspb_back #(
    .RING_BYTES (RING_BYTES)
  ) u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_valid_i          (cmd_valid),
    .cmd_i                (cmd),
    .cmd_pop_o            (cmd_pop),
    .div_start_o          (div_start),
    .div_rsp_i            (div_rsp),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .sample_valid_o       (sample_valid_o),
    .sample_o             (sample_o),
    .read_request_valid_o (read_request_valid_o),
    .read_address_o       (read_address_o),
    .read_count_o         (read_count_o),
    .playing_o            (playing_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(sample_valid_o && read_request_valid_o))
    else $error("Sample and flash read reported in the same word.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && read_request_valid_o) |-> (read_count_o != '0))
    else $error("Flash read requested with a zero byte count.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !read_request_valid_o) |-> (read_address_o == '0 && read_count_o == '0))
    else $error("Read fields are nonzero without a read request.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !sample_valid_o) |-> (sample_o == '0))
    else $error("Sample field is nonzero without a sample.");

endmodule
`default_nettype wire

// ===== src/aspb_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module aspb_front (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [1:0]                        action_i,
  input  wire logic [aspb_pkg::ADDR_W-1:0]       start_address_i,
  input  wire logic [aspb_pkg::LEN_W-1:0]        length_i,
  input  wire logic [aspb_pkg::RATE_W-1:0]       sample_rate_hz_i,
  input  wire logic [aspb_pkg::BYTE_W-1:0]       flash_byte_i,
  output logic                                   cmd_valid_o,
  output aspb_pkg::cmd_t                         cmd_o,
  input  wire logic                              cmd_pop_i
);

  localparam int PTR_W = $clog2(aspb_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(aspb_pkg::QUEUE_DEPTH + 1);

  aspb_pkg::cmd_t     queue_q [aspb_pkg::QUEUE_DEPTH];
  aspb_pkg::cmd_t     cmd_in;
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               push;
  logic               pop;

  always_comb begin
    cmd_in.action         = aspb_pkg::action_e'(action_i);
    cmd_in.rate_zero      = (sample_rate_hz_i == '0);
    cmd_in.start_address  = start_address_i;
    cmd_in.length         = length_i;
    cmd_in.sample_rate_hz = sample_rate_hz_i;
    cmd_in.flash_byte     = flash_byte_i;
  end

  assign in_ready_o  = (count_q != CNT_W'(aspb_pkg::QUEUE_DEPTH));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(aspb_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(aspb_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule
`default_nettype wire

// ===== src/aspb_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module aspb_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [aspb_pkg::RATE_W-1:0]  rate_i,
  output aspb_pkg::div_rsp_t                rsp_o
);

  localparam int DW    = aspb_pkg::DIV_W;
  localparam int RW    = aspb_pkg::RATE_W;
  localparam int CNT_W = $clog2(DW);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DW-1:0]     quo_q;
  logic [RW-1:0]     rem_q;
  logic [RW-1:0]     rate_q;
  logic [RW:0]       shifted;
  logic              ge;
  logic              last;

  assign shifted = {rem_q, quo_q[DW-1]};
  assign ge      = (shifted >= {1'b0, rate_q});
  assign last    = (cnt_q == CNT_W'(DW - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q  <= DW'(aspb_pkg::DIV_NUMER);
      rem_q  <= '0;
      rate_q <= rate_i;
    end else if (busy_q) begin
      rem_q <= ge ? RW'(shifted - {1'b0, rate_q}) : shifted[RW-1:0];
      quo_q <= {quo_q[DW-2:0], ge};
    end
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.divisor = quo_q[aspb_pkg::TICK_W-1:0] + 1'b1;

endmodule
`default_nettype wire

// ===== src/aspb_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module aspb_back #(
  parameter int RING_BYTES = aspb_pkg::RING_BYTES_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cmd_valid_i,
  input  aspb_pkg::cmd_t                         cmd_i,
  output logic                                   cmd_pop_o,
  output logic                                   div_start_o,
  input  aspb_pkg::div_rsp_t                     div_rsp_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic                                   sample_valid_o,
  output logic [aspb_pkg::BYTE_W-1:0]            sample_o,
  output logic                                   read_request_valid_o,
  output logic [aspb_pkg::ADDR_W-1:0]            read_address_o,
  output logic [aspb_pkg::COUNT_W-1:0]           read_count_o,
  output logic                                   playing_o
);

  localparam int IDX_W   = $clog2(RING_BYTES);
  localparam int DEPTH_W = $clog2(RING_BYTES + 1);
  localparam int CW      = aspb_pkg::COUNT_W;
  localparam int FW      = aspb_pkg::FETCH_W;
  localparam int USED_W  = ((DEPTH_W > CW) ? DEPTH_W : CW) + 1;

  aspb_pkg::back_state_e state_q, state_d;

  logic [aspb_pkg::BYTE_W-1:0] ring_mem [RING_BYTES];
  logic [aspb_pkg::BYTE_W-1:0] rd_q;

  logic [IDX_W-1:0]            head_q, tail_q;
  logic                        full_q;
  logic [FW-1:0]               fetch_q, end_q;
  logic [CW-1:0]               outst_q;
  logic [aspb_pkg::TICK_W-1:0] div_q, tick_q;

  logic                        res_sv_q, res_pop_q, res_rrv_q;
  logic [aspb_pkg::ADDR_W-1:0] res_addr_q;
  logic [CW-1:0]               res_cnt_q;

  logic                        out_valid_q;
  logic                        out_free;
  logic                        out_load;

  logic [DEPTH_W-1:0]          depth;
  logic [USED_W-1:0]           used;
  logic [DEPTH_W-1:0]          free_sp;
  logic [DEPTH_W-1:0]          free_m1;
  logic [CW-1:0]               play_cnt;
  logic [FW-1:0]               remain;
  logic                        pump_go;
  logic [CW-1:0]               pump_cnt;
  logic [CW-1:0]               issue_cnt;
  logic [CW:0]                 outst_sum;
  logic [CW-1:0]               outst_add;
  logic [IDX_W-1:0]            head_inc, tail_inc;
  logic                        period_end;
  logic                        is_play_div;

  always_comb begin
    if (full_q) begin
      depth = DEPTH_W'(RING_BYTES);
    end else if (head_q >= tail_q) begin
      depth = DEPTH_W'(head_q) - DEPTH_W'(tail_q);
    end else begin
      depth = DEPTH_W'(RING_BYTES) - DEPTH_W'(tail_q) + DEPTH_W'(head_q);
    end
  end

  assign used     = USED_W'(depth) + USED_W'(outst_q);
  assign free_sp  = (used >= USED_W'(RING_BYTES)) ? '0 : DEPTH_W'(USED_W'(RING_BYTES) - used);
  assign free_m1  = (free_sp == '0) ? '0 : free_sp - 1'b1;
  assign play_cnt = (cmd_i.length < aspb_pkg::LEN_W'(free_m1)) ? cmd_i.length[CW-1:0]
                                                               : CW'(free_m1);
  assign remain   = (fetch_q < end_q) ? end_q - fetch_q : '0;
  assign pump_go  = (remain != '0) && (free_sp > DEPTH_W'(aspb_pkg::PUMP_THRESHOLD));
  assign pump_cnt = (remain < FW'(free_m1)) ? remain[CW-1:0] : CW'(free_m1);

  assign issue_cnt = (cmd_i.action == aspb_pkg::ACT_PLAY) ? play_cnt
                   : (pump_go ? pump_cnt : '0);
  assign outst_sum = {1'b0, outst_q} + {1'b0, issue_cnt};
  assign outst_add = outst_sum[CW] ? {CW{1'b1}} : outst_sum[CW-1:0];

  assign head_inc   = (head_q == IDX_W'(RING_BYTES - 1)) ? '0 : head_q + 1'b1;
  assign tail_inc   = (tail_q == IDX_W'(RING_BYTES - 1)) ? '0 : tail_q + 1'b1;
  assign period_end = (tick_q >= div_q);
  assign out_free   = !out_valid_q || out_ready_i;
  assign is_play_div = (cmd_i.action == aspb_pkg::ACT_PLAY) && !cmd_i.rate_zero;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      aspb_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          state_d = is_play_div ? aspb_pkg::ST_DIV : aspb_pkg::ST_RESP;
        end
      end
      aspb_pkg::ST_DIV: begin
        if (div_rsp_i.done) begin
          state_d = aspb_pkg::ST_RESP;
        end
      end
      aspb_pkg::ST_RESP: begin
        if (out_free) begin
          state_d = aspb_pkg::ST_IDLE;
        end
      end
      default: state_d = aspb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop_o   = 1'b0;
    div_start_o = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      aspb_pkg::ST_IDLE: begin
        cmd_pop_o   = cmd_valid_i;
        div_start_o = cmd_valid_i && is_play_div;
      end
      aspb_pkg::ST_DIV: begin
      end
      aspb_pkg::ST_RESP: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= aspb_pkg::ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      full_q      <= 1'b0;
      fetch_q     <= '0;
      end_q       <= '0;
      outst_q     <= '0;
      div_q       <= aspb_pkg::DIVISOR_RESET;
      tick_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == aspb_pkg::ST_DIV && div_rsp_i.done) begin
        div_q <= div_rsp_i.divisor;
      end
      if (cmd_pop_o) begin
        unique case (cmd_i.action)
          aspb_pkg::ACT_PLAY: begin
            fetch_q <= FW'(cmd_i.start_address) + FW'(play_cnt);
            end_q   <= FW'(cmd_i.start_address) + FW'(cmd_i.length);
            outst_q <= outst_add;
            if (cmd_i.rate_zero) begin
              div_q <= aspb_pkg::DIVISOR_ZERO_RATE;
            end
          end
          aspb_pkg::ACT_BYTE: begin
            if (!full_q) begin
              head_q <= head_inc;
              full_q <= (head_inc == tail_q);
            end
            if (outst_q != '0) begin
              outst_q <= outst_q - 1'b1;
            end
          end
          aspb_pkg::ACT_TICK: begin
            if (period_end) begin
              tick_q <= '0;
              if (depth != '0) begin
                tail_q <= tail_inc;
                full_q <= 1'b0;
              end
            end else begin
              tick_q <= tick_q + 1'b1;
            end
          end
          aspb_pkg::ACT_PUMP: begin
            if (pump_go) begin
              fetch_q <= fetch_q + FW'(pump_cnt);
              outst_q <= outst_add;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && cmd_i.action == aspb_pkg::ACT_BYTE && !full_q) begin
      ring_mem[head_q] <= cmd_i.flash_byte;
    end
    if (cmd_pop_o && cmd_i.action == aspb_pkg::ACT_TICK && period_end && depth != '0) begin
      rd_q <= ring_mem[tail_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      res_sv_q   <= (cmd_i.action == aspb_pkg::ACT_TICK) && period_end;
      res_pop_q  <= (depth != '0);
      res_rrv_q  <= (issue_cnt != '0) &&
                    (cmd_i.action == aspb_pkg::ACT_PLAY || cmd_i.action == aspb_pkg::ACT_PUMP);
      res_addr_q <= (cmd_i.action == aspb_pkg::ACT_PLAY) ? cmd_i.start_address
                                                         : fetch_q[aspb_pkg::ADDR_W-1:0];
      res_cnt_q  <= issue_cnt;
    end
    if (out_load) begin
      sample_valid_o       <= res_sv_q;
      sample_o             <= !res_sv_q ? '0 : (res_pop_q ? rd_q : aspb_pkg::IDLE_SAMPLE);
      read_request_valid_o <= res_rrv_q;
      read_address_o       <= res_rrv_q ? res_addr_q : '0;
      read_count_o         <= res_rrv_q ? res_cnt_q : '0;
      playing_o            <= (depth != '0) || (fetch_q < end_q);
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire
